// ----- rtl/iirt_pkg.sv -----
// Shared widths, formats and reset constants of the order-N transposed direct form II IIR filter.
`timescale 1ns / 1ps

package iirt_pkg;

  localparam int ORDER_DEF = 3;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 20;
  localparam int DELAY_W   = 40;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = DELAY_W + 1;
  localparam int DIFF_W    = DELAY_W + 2;
  localparam int RND_SHIFT = 16;

  localparam logic signed [COEF_W-1:0]   B0_RESET  = COEF_W'(65536);
  localparam logic signed [DELAY_W-1:0]  DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic signed [DELAY_W-1:0]  DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]    RND_HALF  = ACC_W'(32768);

endpackage

// ----- rtl/iirt_mul.sv -----
// Shared registered multiplier: coefficient times sample into a product register.
`timescale 1ns / 1ps

module iirt_mul
  import iirt_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COEF_W-1:0]  coef,
  input  logic signed [SAMPLE_W-1:0] smp,
  output logic signed [PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(coef) * PROD_W'(smp);
    end
  end

endmodule

// ----- rtl/iir_filter_tdf2_top.sv -----
// Top level of the order-N transposed direct form II IIR filter with a shared multiplier.
//
// Use: write the coefficients over cfg_* (index 0..ORDER are b0..bORDER, index ORDER+1..2*ORDER
// are a1..aORDER, all signed Q4.16; higher indexes are ignored); cfg_ready is always high.
// Send Q1.15 samples on in_*; each request yields one Q1.15 result on out_*, with out_tuser set
// when the result was clipped to range.
// Sequence: each sample passes through the accept cycle, the output rounding step and two steps
// per delay tap, all sharing one 20x16 multiplier whose product is registered before it is
// accumulated. in_tready is high only between samples.
// The result waits in a holding register until the output register is free, then is held there
// until taken; the block accepts the next sample while that result waits. If a second result is
// computed before the first is taken, in_tready stays low until the output register frees.
// Reset (rst_n, synchronous, active low) clears the delay line, sets b0 = 1.0 and all other
// coefficients to zero, and empties the output register.
`timescale 1ns / 1ps

module iir_filter_tdf2_top
  import iirt_pkg::*;
#(
  parameter int ORDER = ORDER_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [SAMPLE_W-1:0]                  in_tdata,   // [15:0] sample_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [SAMPLE_W-1:0]                  out_tdata,  // [15:0] sample_out
  output logic                                 out_tuser,  // [0] saturated
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [$clog2(2*ORDER+1)-1:0]         cfg_index,
  input  logic [COEF_W-1:0]                    cfg_data
);

  localparam int NCOEF = 2 * ORDER + 1;
  localparam int CI_W  = $clog2(NCOEF);
  localparam int KW    = $clog2(ORDER + 1);
  localparam int Z1    = (ORDER > 1) ? 1 : 0;
  localparam int SH_W  = ACC_W - RND_SHIFT;

  typedef enum logic [1:0] {S_IDLE, S_Y, S_PB, S_PA} state_t;

  state_t                     state_r;
  logic [KW-1:0]              k_r;
  logic signed [COEF_W-1:0]   coef_r [NCOEF];
  logic signed [DELAY_W-1:0]  z_r [ORDER];
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic                       ysat_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       pend_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_data_r;
  logic                       out_sat_r;

  logic                       in_acc;
  logic                       last_tap;
  logic [CI_W-1:0]            ci;
  logic signed [SAMPLE_W-1:0] mul_smp;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    full;
  logic signed [SH_W-1:0]     sh;
  logic signed [SAMPLE_W-1:0] y_new;
  logic                       ysat_new;
  logic signed [DELAY_W-1:0]  zsrc;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DELAY_W-1:0]  z_new;

  assign in_tready  = (state_r == S_IDLE) && !pend_r;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign last_tap   = (k_r == KW'(ORDER));

  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        ci      = '0;
        mul_smp = $signed(in_tdata);
      end
      S_Y: begin
        ci      = CI_W'(1);
        mul_smp = x_r;
      end
      S_PB: begin
        ci      = CI_W'(ORDER) + CI_W'(k_r);
        mul_smp = y_r;
      end
      default: begin
        ci      = CI_W'(k_r) + CI_W'(1);
        mul_smp = x_r;
      end
    endcase
  end

  iirt_mul u_mul (
    .clk    (clk),
    .en     (in_acc || (state_r != S_IDLE)),
    .coef   (coef_r[ci]),
    .smp    (mul_smp),
    .prod_r (prod)
  );

  // output rounding: round half up to Q1.15, then clamp
  always_comb begin
    full = ACC_W'(z_r[0]) + ACC_W'(prod) + RND_HALF;
    sh   = full[ACC_W-1:RND_SHIFT];
    if (sh > SH_W'(SMP_MAX)) begin
      y_new    = SMP_MAX;
      ysat_new = 1'b1;
    end else if (sh < SH_W'(SMP_MIN)) begin
      y_new    = SMP_MIN;
      ysat_new = 1'b1;
    end else begin
      y_new    = sh[SAMPLE_W-1:0];
      ysat_new = 1'b0;
    end
  end

  always_comb begin
    zsrc = last_tap ? '0 : z_r[Z1];
    diff = DIFF_W'(acc_r) - DIFF_W'(prod);
    if (diff > DIFF_W'(DELAY_MAX)) begin
      z_new = DELAY_MAX;
    end else if (diff < DIFF_W'(DELAY_MIN)) begin
      z_new = DELAY_MIN;
    end else begin
      z_new = diff[DELAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= KW'(1);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= (i == 0) ? B0_RESET : '0;
      end
      for (int i = 0; i < ORDER; i++) begin
        z_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && (CI_W'(cfg_index) <= CI_W'(NCOEF - 1))) begin
        coef_r[CI_W'(cfg_index)] <= $signed(cfg_data);
      end

      if (pend_r && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= y_r;
        out_sat_r   <= ysat_r;
        pend_r      <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r     <= $signed(in_tdata);
            state_r <= S_Y;
          end
        end
        S_Y: begin
          y_r     <= y_new;
          ysat_r  <= ysat_new;
          pend_r  <= 1'b1;
          k_r     <= KW'(1);
          state_r <= S_PB;
        end
        S_PB: begin
          acc_r   <= ACC_W'(zsrc) + ACC_W'(prod);
          state_r <= S_PA;
        end
        default: begin
          // rotate so the next source tap sits at position 1
          for (int i = 0; i < ORDER - 1; i++) begin
            z_r[i] <= z_r[i+1];
          end
          z_r[ORDER-1] <= z_new;
          if (last_tap) begin
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + KW'(1);
            state_r <= S_PB;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_Y))
    else $error("accepted request did not start rounding step");

  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Y) |=> pend_r)
    else $error("rounded result not queued for output");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PB) || (state_r == S_PA)) |-> ((k_r >= KW'(1)) && (k_r <= KW'(ORDER))))
    else $error("tap counter out of range");

  a_last_tap_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PA) && last_tap) |=> (state_r == S_IDLE))
    else $error("sequencer did not finish after last tap");

  a_y_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PB) || (state_r == S_PA)) |=> $stable(y_r))
    else $error("feedback sample changed during tap updates");
`endif

endmodule
